// ===== hw/rtl/wrf_pkg.sv =====
// ============================================================================
// Windowed register file package
// Shared codes, constants and word types of the windowed register file with
// trap entry.
// ============================================================================
`default_nettype none

package wrf_pkg;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TRAP  = 2'd2;

    // Register number bits 4:3 select the group.
    localparam logic [1:0] REGION_GLOBAL = 2'd0;
    localparam logic [1:0] REGION_OUT    = 2'd1;
    localparam logic [1:0] REGION_LOCAL  = 2'd2;
    localparam logic [1:0] REGION_IN     = 2'd3;

    // Slots of l1 and l2 within a bank of eight locals.
    localparam logic [2:0] L1_SLOT = 3'd1;
    localparam logic [2:0] L2_SLOT = 3'd2;

    // Trap base bits replaced by the trap code, and the interrupt code base.
    localparam logic [31:0] VEC_MASK = 32'h0000_0ff0;
    localparam logic [7:0]  INT_BASE = 8'h10;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  reg_num;
        logic [31:0] write_data;
        logic [2:0]  cur_window;
        logic [7:0]  pending_trap;
        logic [3:0]  int_level;
        logic [3:0]  int_mask_level;
        logic        traps_enabled;
        logic        supervisor;
        logic [31:0] prog_counter;
        logic [31:0] next_prog_counter;
        logic [31:0] trap_base;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic        trap_taken;
        logic [7:0]  trap_code;
        logic [2:0]  new_window;
        logic [31:0] new_pc;
        logic [31:0] new_npc;
        logic        new_traps_enabled;
        logic        new_supervisor;
        logic        new_prev_supervisor;
        logic        error;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hw/rtl/windowed_register_file_trap_entry.sv =====
// ============================================================================
// Windowed register file with trap entry
// Integer register file with overlapping windows, plus trap and interrupt
// entry that saves pc and npc into the new window.
// ============================================================================
// Usage:
// Words enter on the input channel (i_in_valid, o_in_stall, i_in_word) and
// results leave on the output channel (o_out_valid, i_out_stall, o_out_word).
// Every input word gives exactly one result word.
// All registers live in one RAM with one write port and a registered read.
// A read result is registered from the RAM data in S_READ, the state after
// the accepting edge. A write, a check that takes no trap and a taken trap
// all register their result at the accepting edge itself. A taken trap
// writes l1 in the accept cycle and l2 in the following one.
// Reads and taken traps pass through S_READ or S_TRAP, where no new word is
// taken, because of the single RAM write port and the registered RAM read;
// other words go at one word per cycle while the receiver does not stall.
// After reset the block zeroes all 8 + 16 * NUM_WINDOWS RAM entries (136 at
// the default), one entry per cycle, holding o_in_stall high.
// The result sits in an output register. While the receiver stalls, that
// word holds, and a new word is accepted only if the held word leaves in the
// same cycle. Global g0 is never written, so its entry keeps the zero from
// the clearing sweep and needs no special read path.
// ============================================================================
`default_nettype none

module windowed_register_file_trap_entry
    import wrf_pkg::*;
#(
    parameter int NUM_WINDOWS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    // Window index width, and a wider width that holds cur_window and the
    // window count while folding the pointer into range.
    localparam int WIN_W      = $clog2(NUM_WINDOWS);
    localparam int TMP_W      = WIN_W + 3;
    localparam int FOLD_STEPS = (8 + NUM_WINDOWS - 1) / NUM_WINDOWS;

    // RAM layout: globals, then the outs of every window, then the locals.
    localparam int OUT_BASE = 8;
    localparam int LOC_BASE = 8 + 8 * NUM_WINDOWS;
    localparam int DEPTH    = 8 + 16 * NUM_WINDOWS;
    localparam int ADDR_W   = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_TRAP
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;
    t_out_word         r_res, n_res;
    logic [ADDR_W-1:0] r_l2_addr, n_l2_addr;
    logic [31:0]       r_l2_data, n_l2_data;

    logic              in_acc;
    logic [TMP_W-1:0]  fold;
    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  win_prev;
    logic [WIN_W-1:0]  win_next;
    logic [1:0]        region;
    logic [2:0]        reg_low;
    logic [ADDR_W-1:0] reg_addr;
    logic [ADDR_W-1:0] l1_addr;
    logic [ADDR_W-1:0] l2_addr;
    logic              trap_go;
    logic              trap_err;
    logic [7:0]        code;
    logic [31:0]       vec;
    t_out_word         res;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;

    // A new word is taken only from idle, and only when the output register
    // is empty or its word leaves at this edge.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    // The current window pointer is reduced modulo the window count by FOLD_STEPS
    // conditional subtractions; cur_window is only three bits wide.
    always_comb begin
        fold = TMP_W'(i_in_word.cur_window);
        for (int k = 0; k < FOLD_STEPS; k++) begin
            if (fold >= TMP_W'(NUM_WINDOWS)) begin
                fold = fold - TMP_W'(NUM_WINDOWS);
            end
        end
    end

    assign win      = fold[WIN_W-1:0];
    assign win_prev = (win == '0) ? WIN_W'(NUM_WINDOWS - 1) : win - 1'b1;
    assign win_next = (win == WIN_W'(NUM_WINDOWS - 1)) ? '0 : win + 1'b1;

    assign region  = i_in_word.reg_num[4:3];
    assign reg_low = i_in_word.reg_num[2:0];

    // The ins of this window are the outs of the next one.
    always_comb begin
        unique case (region)
            REGION_GLOBAL: reg_addr = ADDR_W'(reg_low);
            REGION_OUT:    reg_addr = ADDR_W'({win, reg_low}) + ADDR_W'(OUT_BASE);
            REGION_LOCAL:  reg_addr = ADDR_W'({win, reg_low}) + ADDR_W'(LOC_BASE);
            REGION_IN:     reg_addr = ADDR_W'({win_next, reg_low}) + ADDR_W'(OUT_BASE);
        endcase
    end

    assign l1_addr = ADDR_W'({win_prev, L1_SLOT}) + ADDR_W'(LOC_BASE);
    assign l2_addr = ADDR_W'({win_prev, L2_SLOT}) + ADDR_W'(LOC_BASE);

    // A pending trap wins over an interrupt. A pending trap with traps
    // disabled is an error and changes nothing.
    assign trap_err = (i_in_word.mode == MODE_TRAP) && (i_in_word.pending_trap != '0)
                      && !i_in_word.traps_enabled;
    assign trap_go  = (i_in_word.mode == MODE_TRAP) && i_in_word.traps_enabled
                      && ((i_in_word.pending_trap != '0)
                          || (i_in_word.int_level > i_in_word.int_mask_level));
    assign code     = (i_in_word.pending_trap != '0) ? i_in_word.pending_trap
                      : INT_BASE + 8'(i_in_word.int_level);
    assign vec      = (i_in_word.trap_base & ~VEC_MASK) | (32'(code) << 4);

    always_comb begin
        res.read_data           = '0;
        res.trap_taken          = trap_go;
        res.trap_code           = trap_go ? code : '0;
        res.new_window          = trap_go ? 3'(TMP_W'(win_prev)) : i_in_word.cur_window;
        res.new_pc              = trap_go ? vec : '0;
        res.new_npc             = trap_go ? vec + 32'd4 : '0;
        res.new_traps_enabled   = trap_go ? 1'b0 : i_in_word.traps_enabled;
        res.new_supervisor      = trap_go ? 1'b1 : i_in_word.supervisor;
        res.new_prev_supervisor = trap_go ? i_in_word.supervisor : 1'b0;
        res.error               = trap_err;
    end

    // Sequencer. Every write is committed at an earlier edge than the one at
    // which the next word can issue its read, so no forwarding path is needed.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_res       = r_res;
        n_l2_addr   = r_l2_addr;
        n_l2_data   = r_l2_data;
        mem_we      = 1'b0;
        mem_waddr   = reg_addr;
        mem_wdata   = i_in_word.write_data;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.mode)
                        MODE_READ: begin
                            n_res   = res;
                            n_state = S_READ;
                        end
                        MODE_WRITE: begin
                            mem_we      = (i_in_word.reg_num != '0);
                            n_out       = res;
                            n_out_valid = 1'b1;
                        end
                        MODE_TRAP: begin
                            if (trap_go) begin
                                mem_we    = 1'b1;
                                mem_waddr = l1_addr;
                                mem_wdata = i_in_word.prog_counter;
                                n_l2_addr = l2_addr;
                                n_l2_data = i_in_word.next_prog_counter;
                                n_state   = S_TRAP;
                            end
                            n_out       = res;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out       = res;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out           = r_res;
                n_out.read_data = mem_rdata;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            S_TRAP: begin
                mem_we    = 1'b1;
                mem_waddr = r_l2_addr;
                mem_wdata = r_l2_data;
                n_state   = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_res     <= n_res;
        r_l2_addr <= n_l2_addr;
        r_l2_data <= n_l2_data;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    wrf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (reg_addr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // No word is taken while the RAM is being cleared.
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("word accepted during RAM clear");

    // When read data lands, the output register must be free for it.
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite a held word");

    // A taken trap always goes on to write l2.
    a_trap_second_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && trap_go) |=> (r_state == S_TRAP) && mem_we)
        else $error("trap entry missed the l2 write");

    // Global g0 is written only by the clearing sweep.
    a_g0_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (mem_waddr == '0)) |-> (r_state == S_CLEAR))
        else $error("write to g0 outside the clearing sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/wrf_ram.sv =====
// ============================================================================
// Windowed register file RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module wrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 136,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
